>>> rtl/core/change_event_coalescer_core_assert.svh
// assertion macros used by the coalescer datapath
`ifndef CHANGE_EVENT_COALESCER_CORE_ASSERT_SVH
`define CHANGE_EVENT_COALESCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/cec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cec_pkg;

    localparam int KIND_W  = 4;
    localparam int FILE_W  = 16;
    localparam int TIME_W  = 48;
    localparam int CFG_W   = 32;
    localparam int READY_W = TIME_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    // event kinds
    localparam logic [KIND_W-1:0] K_CHANGED    = 4'd0;
    localparam logic [KIND_W-1:0] K_DONE       = 4'd1;
    localparam logic [KIND_W-1:0] K_DELETED    = 4'd2;
    localparam logic [KIND_W-1:0] K_CREATED    = 4'd3;
    localparam logic [KIND_W-1:0] K_ATTR       = 4'd4;
    localparam logic [KIND_W-1:0] K_PREUNMOUNT = 4'd5;
    localparam logic [KIND_W-1:0] K_UNMOUNTED  = 4'd6;
    localparam logic [KIND_W-1:0] K_MOVED      = 4'd7;
    localparam logic [KIND_W-1:0] K_RENAMED    = 4'd8;
    localparam logic [KIND_W-1:0] K_MOVED_IN   = 4'd9;
    localparam logic [KIND_W-1:0] K_MOVED_OUT  = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_MOVES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_MOVED = 2'd3;

    localparam logic [CFG_W-1:0] RATE_LIMIT_RST = 32'd800000;
    localparam logic [CFG_W-1:0] DONE_DELAY_RST = 32'd2000000;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FILE_W-1:0] file;
        logic [FILE_W-1:0] other;
        logic              other_valid;
        logic              dropped;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic step_fo;
        logic step_ff;
        logic step_main;
        logic step_cr;
        logic disp_act;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic emit_ok;
        logic is_dispatch;
        logic is_ignored;
        logic disp_go;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/cec_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/cec_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "change_event_coalescer_core_assert.svh"

module cec_datapath #(
    parameter int ENTRIES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_mode,
    input  wire logic [cec_pkg::KIND_W-1:0]    s_event_kind,
    input  wire logic [cec_pkg::FILE_W-1:0]    s_file_id,
    input  wire logic [cec_pkg::FILE_W-1:0]    s_other_id,
    input  wire logic                          s_other_valid,
    input  wire logic [cec_pkg::TIME_W-1:0]    s_event_time,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cec_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [cec_pkg::KIND_W-1:0]    m_out_kind,
    output logic      [cec_pkg::FILE_W-1:0]    m_out_file,
    output logic      [cec_pkg::FILE_W-1:0]    m_out_other,
    output logic                               m_out_other_valid,
    output logic                               m_last,
    output logic                               m_dropped,
    input  wire cec_pkg::cmd_t                 cmd,
    output cec_pkg::status_t                   status
);
    import cec_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W:0] ENT_C = (IDX_W + 1)'(ENTRIES);

    // configuration
    logic [CFG_W-1:0] rate_limit_reg;
    logic [CFG_W-1:0] done_delay_reg;
    logic             watch_moves_reg;
    logic             send_moved_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_limit_reg  <= RATE_LIMIT_RST;
            done_delay_reg  <= DONE_DELAY_RST;
            watch_moves_reg <= 1'b0;
            send_moved_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RATE_LIMIT:  rate_limit_reg  <= cfg_wdata;
                CFG_DONE_DELAY:  done_delay_reg  <= cfg_wdata;
                CFG_WATCH_MOVES: watch_moves_reg <= cfg_wdata[0];
                CFG_SEND_MOVED:  send_moved_reg  <= cfg_wdata[0];
            endcase
        end
    end

    // latched input word
    logic              it_mode_reg;
    logic [KIND_W-1:0] it_kind_reg;
    logic [FILE_W-1:0] it_file_reg;
    logic [FILE_W-1:0] it_other_reg;
    logic              it_ov_reg;
    logic [TIME_W-1:0] it_time_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            it_mode_reg  <= s_mode;
            it_kind_reg  <= s_event_kind;
            it_file_reg  <= s_file_id;
            it_other_reg <= s_other_id;
            it_ov_reg    <= s_other_valid;
            it_time_reg  <= s_event_time;
        end
    end

    // slot scan counter, one read per cycle
    logic [IDX_W:0]   scan_cnt_reg;
    logic             rd_v_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue;

    assign issue = scan_cnt_reg < ENT_C;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= ENT_C;
            rd_v_reg     <= 1'b0;
        end else if (cmd.scan_start) begin
            scan_cnt_reg <= '0;
            rd_v_reg     <= 1'b0;
        end else begin
            rd_v_reg <= issue;
            if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
    end

    // slot storage
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [FILE_W-1:0]  file_q;
    logic               dirty_q;
    logic [TIME_W-1:0]  stamp_q;

    logic             add;
    logic [IDX_W-1:0] add_idx;
    logic             dirty_we;
    logic [IDX_W-1:0] dirty_addr;
    logic             dirty_wdata;
    logic             stamp_we;
    logic [IDX_W-1:0] stamp_addr;

    cec_ram #(.WIDTH(FILE_W), .DEPTH(ENTRIES)) u_file_ram (
        .clk     (aclk),
        .wr_en   (add),
        .wr_addr (add_idx),
        .wr_data (it_file_reg),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (file_q)
    );

    cec_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_dirty_ram (
        .clk     (aclk),
        .wr_en   (dirty_we),
        .wr_addr (dirty_addr),
        .wr_data (dirty_wdata),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (dirty_q)
    );

    cec_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk     (aclk),
        .wr_en   (stamp_we),
        .wr_addr (stamp_addr),
        .wr_data (it_time_reg),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (stamp_q)
    );

    // scan results: file match, partner match, first free, earliest ready
    logic               mf_found_reg, mo_found_reg, fr_found_reg, bs_found_reg;
    logic [IDX_W-1:0]   mf_idx_reg, mo_idx_reg, fr_idx_reg, bs_idx_reg;
    logic [READY_W-1:0] bs_ready_reg;
    logic               bs_dirty_reg;
    logic [FILE_W-1:0]  bs_file_reg;
    logic               rd_live;
    logic [READY_W-1:0] ready_calc;

    assign rd_live    = valid_reg[rd_idx_reg];
    assign ready_calc = {1'b0, stamp_q}
                      + READY_W'(dirty_q ? rate_limit_reg : done_delay_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_start) begin
            mf_found_reg <= 1'b0;
            mo_found_reg <= 1'b0;
            fr_found_reg <= 1'b0;
            bs_found_reg <= 1'b0;
        end else if (rd_v_reg) begin
            if (rd_live && file_q == it_file_reg && !mf_found_reg) begin
                mf_found_reg <= 1'b1;
                mf_idx_reg   <= rd_idx_reg;
            end
            if (rd_live && file_q == it_other_reg && !mo_found_reg) begin
                mo_found_reg <= 1'b1;
                mo_idx_reg   <= rd_idx_reg;
            end
            if (!rd_live && !fr_found_reg) begin
                fr_found_reg <= 1'b1;
                fr_idx_reg   <= rd_idx_reg;
            end
            // strict compare keeps the lower slot on ties
            if (rd_live && (!bs_found_reg || ready_calc < bs_ready_reg)) begin
                bs_found_reg <= 1'b1;
                bs_idx_reg   <= rd_idx_reg;
                bs_ready_reg <= ready_calc;
                bs_dirty_reg <= dirty_q;
                bs_file_reg  <= file_q;
            end
        end
    end

    // event decode
    logic              is_ignored;
    logic              do_flush_other;
    logic              do_flush_file;
    logic              has_main;
    logic [KIND_W-1:0] main_kind;
    logic              main_pass_other;
    logic              main_force_ov;
    logic              main_add;
    logic              main_set_dirty;
    logic              has_cr;

    always_comb begin
        is_ignored      = 1'b0;
        do_flush_other  = 1'b0;
        do_flush_file   = 1'b0;
        has_main        = 1'b0;
        main_kind       = it_kind_reg;
        main_pass_other = 1'b0;
        main_force_ov   = 1'b0;
        main_add        = 1'b0;
        main_set_dirty  = 1'b0;
        has_cr          = 1'b0;
        unique case (it_kind_reg)
            K_CHANGED: begin
                has_main       = !mf_found_reg;
                main_add       = !mf_found_reg;
                main_set_dirty = mf_found_reg;
            end
            K_DONE: begin
                do_flush_file = 1'b1;
            end
            K_CREATED: begin
                do_flush_file = 1'b1;
                has_main      = 1'b1;
                main_add      = 1'b1;
            end
            K_DELETED, K_ATTR, K_PREUNMOUNT, K_UNMOUNTED: begin
                do_flush_file = 1'b1;
                has_main      = 1'b1;
            end
            K_MOVED_IN: begin
                do_flush_file = 1'b1;
                has_main      = 1'b1;
                if (watch_moves_reg) begin
                    main_pass_other = 1'b1;
                end else begin
                    main_kind = K_CREATED;
                    main_add  = 1'b1;
                end
            end
            K_MOVED_OUT: begin
                do_flush_file = 1'b1;
                has_main      = 1'b1;
                if (watch_moves_reg) begin
                    main_pass_other = 1'b1;
                end else if (send_moved_reg) begin
                    main_kind       = K_MOVED;
                    main_pass_other = 1'b1;
                end else begin
                    main_kind = K_DELETED;
                end
            end
            K_RENAMED: begin
                do_flush_file = 1'b1;
                has_main      = 1'b1;
                if (watch_moves_reg || send_moved_reg) begin
                    do_flush_other = 1'b1;
                    main_force_ov  = 1'b1;
                    main_kind      = watch_moves_reg ? K_RENAMED : K_MOVED;
                end else begin
                    main_kind = K_DELETED;
                    has_cr    = 1'b1;
                end
            end
            default: begin
                is_ignored = 1'b1;
            end
        endcase
    end

    // step actions
    logic ff_did_reg;
    logic fo_hit, ff_hit, main_hit, cr_hit, disp_hit, set_dirty_hit;
    logic emit, can_add;
    res_t emit_res;

    assign fo_hit   = cmd.step_fo && do_flush_other && mo_found_reg;
    assign ff_hit   = cmd.step_ff && do_flush_file && mf_found_reg && valid_reg[mf_idx_reg];
    assign main_hit = cmd.step_main && has_main;
    assign cr_hit   = cmd.step_cr && has_cr;
    assign disp_hit = cmd.disp_act;
    assign set_dirty_hit = cmd.step_main && main_set_dirty;
    assign emit     = fo_hit || ff_hit || main_hit || cr_hit || disp_hit;

    // lowest free slot after a flush of this file
    assign can_add = fr_found_reg || ff_did_reg;
    assign add_idx = (ff_did_reg && (!fr_found_reg || mf_idx_reg < fr_idx_reg))
                   ? mf_idx_reg : fr_idx_reg;
    assign add     = ((main_hit && main_add) || cr_hit) && can_add;

    always_comb begin
        emit_res = '0;
        priority if (fo_hit) begin
            emit_res.kind = K_DONE;
            emit_res.file = it_other_reg;
        end else if (ff_hit) begin
            emit_res.kind = K_DONE;
            emit_res.file = it_file_reg;
        end else if (main_hit) begin
            emit_res.kind    = main_kind;
            emit_res.file    = it_file_reg;
            emit_res.dropped = main_add && !can_add;
            if (main_force_ov) begin
                emit_res.other       = it_other_reg;
                emit_res.other_valid = 1'b1;
            end else if (main_pass_other && it_ov_reg) begin
                emit_res.other       = it_other_reg;
                emit_res.other_valid = 1'b1;
            end
        end else if (cr_hit) begin
            emit_res.kind    = K_CREATED;
            emit_res.file    = it_file_reg;
            emit_res.dropped = !can_add;
        end else if (disp_hit) begin
            emit_res.kind = bs_dirty_reg ? K_CHANGED : K_DONE;
            emit_res.file = bs_file_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (fo_hit) begin
            valid_next[mo_idx_reg] = 1'b0;
        end
        if (ff_hit) begin
            valid_next[mf_idx_reg] = 1'b0;
        end
        if (disp_hit && !bs_dirty_reg) begin
            valid_next[bs_idx_reg] = 1'b0;
        end
        if (add) begin
            valid_next[add_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // table writes: new record, dirty mark, dispatch re-stamp
    assign dirty_we    = add || set_dirty_hit || (disp_hit && bs_dirty_reg);
    assign dirty_addr  = add ? add_idx : (set_dirty_hit ? mf_idx_reg : bs_idx_reg);
    assign dirty_wdata = set_dirty_hit && !add;
    assign stamp_we    = add || (disp_hit && bs_dirty_reg);
    assign stamp_addr  = add ? add_idx : bs_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.accept) begin
            ff_did_reg <= 1'b0;
        end else if (cmd.step_ff) begin
            ff_did_reg <= ff_hit;
        end
    end

    // result count for the dispatch limit
    logic [CNT_W-1:0] res_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.accept) begin
            res_cnt_reg <= '0;
        end else if (emit) begin
            res_cnt_reg <= res_cnt_reg + 1'b1;
        end
    end

    // hold stage keeps one result back so the final one can carry last
    res_t hold_reg;
    logic hold_valid_reg;
    res_t out_reg;
    logic out_last_reg;
    logic out_valid_reg;
    logic out_free;
    logic move;

    assign out_free = !out_valid_reg || m_ready;
    assign move     = hold_valid_reg && (emit || cmd.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (emit) begin
                hold_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                hold_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            hold_reg <= emit_res;
        end
        if (move) begin
            out_reg      <= hold_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_out_kind        = out_reg.kind;
    assign m_out_file        = out_reg.file;
    assign m_out_other       = out_reg.other;
    assign m_out_other_valid = out_reg.other_valid;
    assign m_last            = out_last_reg;
    assign m_dropped         = out_reg.dropped;

    // status
    assign status.scan_done   = !issue && !rd_v_reg;
    assign status.emit_ok     = !hold_valid_reg || out_free;
    assign status.is_dispatch = it_mode_reg;
    assign status.is_ignored  = is_ignored;
    assign status.disp_go     = (res_cnt_reg < CNT_W'(MAX_RESULTS)) && bs_found_reg
                              && (bs_ready_reg <= {1'b0, it_time_reg});

    // checks
    `CEC_ASSERT_IMP(a_emit_room, aclk, aresetn, emit && hold_valid_reg, out_free, "result overwritten")
    `CEC_ASSERT_IMP(a_add_free, aclk, aresetn, add, !valid_reg[add_idx], "record stored over a live slot")
    `CEC_ASSERT(a_res_limit, aclk, aresetn, res_cnt_reg <= CNT_W'(MAX_RESULTS), "too many results")

endmodule

`default_nettype wire

>>> rtl/core/cec_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cec_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cec_pkg::status_t status,
    output cec_pkg::cmd_t         cmd
);
    import cec_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FO,
        ST_FF,
        ST_MAIN,
        ST_CR,
        ST_DACT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // step sequencing
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept     = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    priority if (status.is_dispatch) begin
                        state_next = ST_DACT;
                    end else if (status.is_ignored) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_FO;
                    end
                end
            end
            ST_FO: begin
                if (status.emit_ok) begin
                    cmd.step_fo = 1'b1;
                    state_next  = ST_FF;
                end
            end
            ST_FF: begin
                if (status.emit_ok) begin
                    cmd.step_ff = 1'b1;
                    state_next  = ST_MAIN;
                end
            end
            ST_MAIN: begin
                if (status.emit_ok) begin
                    cmd.step_main = 1'b1;
                    state_next    = ST_CR;
                end
            end
            ST_CR: begin
                if (status.emit_ok) begin
                    cmd.step_cr = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_DACT: begin
                if (status.emit_ok) begin
                    if (status.disp_go) begin
                        cmd.disp_act   = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (status.emit_ok) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/change_event_coalescer_core.sv
// file event: slot scan, then five steps (flush other, flush file, main, created, finish), then accept
// ignored kinds: slot scan, then finish; output stalls stretch every step that emits a result
// dispatch tick: one slot scan per drained record plus a final scan, at most 16 records drained
// one word at a time; the slot scan through the table memories sets the rate
// the next word is taken once the last result of this one sits in the output stage
// reset (synchronous, active low) frees every slot and restores register defaults
`timescale 1ns / 1ps
`default_nettype none

module change_event_coalescer_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [cec_pkg::KIND_W-1:0]    s_event_kind,
    input  wire logic [cec_pkg::FILE_W-1:0]    s_file_id,
    input  wire logic [cec_pkg::FILE_W-1:0]    s_other_id,
    input  wire logic                          s_other_valid,
    input  wire logic [cec_pkg::TIME_W-1:0]    s_event_time,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cec_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [cec_pkg::KIND_W-1:0]    m_out_kind,
    output logic      [cec_pkg::FILE_W-1:0]    m_out_file,
    output logic      [cec_pkg::FILE_W-1:0]    m_out_other,
    output logic                               m_out_other_valid,
    output logic                               m_last,
    output logic                               m_dropped
);
    import cec_pkg::*;

    cmd_t    cmd;
    status_t status;

    cec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cec_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_mode            (s_mode),
        .s_event_kind      (s_event_kind),
        .s_file_id         (s_file_id),
        .s_other_id        (s_other_id),
        .s_other_valid     (s_other_valid),
        .s_event_time      (s_event_time),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_kind        (m_out_kind),
        .m_out_file        (m_out_file),
        .m_out_other       (m_out_other),
        .m_out_other_valid (m_out_other_valid),
        .m_last            (m_last),
        .m_dropped         (m_dropped),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

`default_nettype wire
